### rtl/core/imhq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants for the indexed min-heap queue.
// ---------------------------------------------------------------------------
package imhq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int VERTICES  = 1024;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int VTX_W     = $clog2(VERTICES);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = SLOT_W + 1;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_DECREASE = 2'd1,
        REQ_EXTRACT  = 2'd2,
        REQ_NOP      = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_NOT_LOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [VTX_W-1:0]    vertex;
        logic [KEY_BITS-1:0] new_key;
    } req_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [VTX_W-1:0]    out_vertex;
        logic [KEY_BITS-1:0] out_key;
        logic [CNT_W-1:0]    count;
        logic                is_empty;
    } rsp_item_t;

endpackage

### rtl/core/imhq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imhq_ram
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module imhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read one entry per cycle, and write it as well when we is set
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/indexed_min_heap_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap with per-vertex position table.
// ---------------------------------------------------------------------------
// Usage: one request transfer on req (insert, decrease key, extract min)
// gives exactly one response transfer on rsp with status, extracted vertex
// and key, and the count after the request. Requests are served one at a
// time; req_ready is low while a request is in flight.
// Heap slots, keys and positions sit in three single-port RAMs with a
// registered read. Each sift-up level walks S_UP_PAR, S_UP_PKEY and
// S_UP_CMP; each sift-down level walks S_DN_L, S_DN_LK, S_DN_R, S_DN_RK
// (only when a right child exists) and S_DN_CMP. A rejected insert or
// decrease goes through S_POS_RD and S_POS_CHK to S_RSP, an extract from
// an empty heap through S_EX_RD0 to S_RSP, and extracting the only element
// skips the sift-down. The next request is taken once the response
// transfer has happened and rsp_valid has dropped.
// After reset a clearing pass writes "absent" into every position entry,
// one per cycle, before the first request is taken.
// The response is held in an output register; when the receiver stalls,
// req_ready stays low until the response transfer has happened.
// ---------------------------------------------------------------------------
module indexed_min_heap_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  imhq_pkg::req_item_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output imhq_pkg::rsp_item_t  rsp
);
    import imhq_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_POS_RD, S_POS_CHK, S_EX_RD0, S_EX_KEY0, S_EX_LAST,
        S_EX_KEYL, S_UP_PAR, S_UP_PKEY, S_UP_CMP, S_DN_L, S_DN_LK, S_DN_R,
        S_DN_RK, S_DN_CMP, S_FIN, S_RSP
    } state_t;

    state_t               state_reg;
    logic [VTX_W-1:0]     clr_reg;
    req_t                 op_reg;
    logic [VTX_W-1:0]     v_reg;
    logic [KEY_BITS-1:0]  k_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SLOT_W-1:0]    ch_reg;
    logic [VTX_W-1:0]     cv_reg;
    logic [KEY_BITS-1:0]  ck_reg;
    logic [VTX_W-1:0]     top_reg;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_reg;

    // ram ports
    logic                 hs_we, vk_we, vp_we;
    logic [SLOT_W-1:0]    hs_addr;
    logic [VTX_W-1:0]     vk_addr, vp_addr;
    logic [VTX_W-1:0]     hs_wdata, hs_rdata;
    logic [KEY_BITS-1:0]  vk_wdata, vk_rdata;
    logic [POS_W-1:0]     vp_wdata, vp_rdata;

    imhq_ram #(.DEPTH(CAPACITY), .WIDTH(VTX_W)) u_slots (
        .clk(clk), .we(hs_we), .addr(hs_addr), .wdata(hs_wdata), .rdata(hs_rdata));
    imhq_ram #(.DEPTH(VERTICES), .WIDTH(KEY_BITS)) u_keys (
        .clk(clk), .we(vk_we), .addr(vk_addr), .wdata(vk_wdata), .rdata(vk_rdata));
    imhq_ram #(.DEPTH(VERTICES), .WIDTH(POS_W)) u_pos (
        .clk(clk), .we(vp_we), .addr(vp_addr), .wdata(vp_wdata), .rdata(vp_rdata));

    // slot arithmetic: last slot, parent, left and right child
    logic [SLOT_W-1:0] last_w;
    logic [SLOT_W-1:0] par_w;
    logic [SLOT_W:0]   child_w;
    logic [CNT_W-1:0]  rch_w;
    assign last_w  = SLOT_W'(cnt_reg - CNT_W'(1));
    assign par_w   = (idx_reg - SLOT_W'(1)) >> 1;
    assign child_w = {idx_reg, 1'b1};
    assign rch_w   = {1'b0, ch_reg} + CNT_W'(1);

    // ram access per state
    always_comb
    begin
        hs_we = 1'b0; vk_we = 1'b0; vp_we = 1'b0;
        hs_addr = idx_reg; vk_addr = v_reg; vp_addr = v_reg;
        hs_wdata = v_reg; vk_wdata = k_reg; vp_wdata = {1'b0, idx_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                vp_we = 1'b1; vp_addr = clr_reg; vp_wdata = {1'b1, {SLOT_W{1'b0}}};
            end
            S_EX_RD0:   hs_addr = '0;
            S_EX_KEY0:
            begin
                vk_addr = hs_rdata;
                hs_addr = last_w;
            end
            S_EX_LAST:
            begin
                // fetch key of last element, mark extracted vertex absent
                vk_addr = hs_rdata;
                vp_we = 1'b1; vp_addr = top_reg;
                vp_wdata = {1'b1, {SLOT_W{1'b0}}};
            end
            S_EX_KEYL:
            begin
                hs_we = 1'b1; hs_addr = SLOT_W'(cnt_reg); hs_wdata = top_reg;
            end
            S_UP_PAR:   hs_addr = par_w;
            S_UP_PKEY:  vk_addr = hs_rdata;
            S_UP_CMP:
            begin
                // parent strictly greater: move parent down
                if (vk_rdata > k_reg)
                begin
                    hs_we = 1'b1; hs_wdata = cv_reg;
                    vp_we = 1'b1; vp_addr = cv_reg;
                end
            end
            S_DN_L:     hs_addr = child_w[SLOT_W-1:0];
            S_DN_LK:
            begin
                vk_addr = hs_rdata;
                hs_addr = rch_w[SLOT_W-1:0];
            end
            S_DN_R:
            begin
                vk_addr = hs_rdata;
                hs_addr = rch_w[SLOT_W-1:0];
            end
            S_DN_CMP:
            begin
                // own key strictly greater: move child up
                if (k_reg > ck_reg)
                begin
                    hs_we = 1'b1; hs_wdata = cv_reg;
                    vp_we = 1'b1; vp_addr = cv_reg;
                end
            end
            S_FIN:
            begin
                hs_we = 1'b1; vp_we = 1'b1;
                vk_we = (op_reg != REQ_EXTRACT);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            op_reg        <= REQ_NOP;
            v_reg         <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            cv_reg        <= '0;
            ck_reg        <= '0;
            top_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (state_reg != S_RSP && rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + VTX_W'(1);
                    if (clr_reg == VTX_W'(VERTICES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        op_reg  <= req_t'(req.req_type);
                        v_reg   <= req.vertex;
                        k_reg   <= req.new_key;
                        rsp_reg <= '0;
                        unique case (req.req_type)
                            REQ_INSERT, REQ_DECREASE: state_reg <= S_POS_RD;
                            REQ_EXTRACT:              state_reg <= S_EX_RD0;
                            default:                  state_reg <= S_RSP;
                        endcase
                    end
                end
                S_POS_RD: state_reg <= S_POS_CHK;
                S_POS_CHK:
                begin
                    if (op_reg == REQ_INSERT)
                    begin
                        if (!vp_rdata[POS_W-1] || cnt_reg >= CNT_W'(CAPACITY))
                        begin
                            rsp_reg.status <= ST_FULL;
                            state_reg <= S_RSP;
                        end
                        else
                        begin
                            idx_reg <= SLOT_W'(cnt_reg);
                            cnt_reg <= cnt_reg + CNT_W'(1);
                            state_reg <= S_UP_PAR;
                        end
                    end
                    else if (vp_rdata[POS_W-1])
                    begin
                        rsp_reg.status <= ST_ABSENT;
                        state_reg <= S_RSP;
                    end
                    else if (!(k_reg < vk_rdata))
                    begin
                        rsp_reg.status <= ST_NOT_LOW;
                        state_reg <= S_RSP;
                    end
                    else
                    begin
                        idx_reg <= vp_rdata[SLOT_W-1:0];
                        state_reg <= S_UP_PAR;
                    end
                end
                S_UP_PAR:
                begin
                    state_reg <= (idx_reg == '0) ? S_FIN : S_UP_PKEY;
                end
                S_UP_PKEY:
                begin
                    cv_reg <= hs_rdata;
                    state_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (vk_rdata > k_reg)
                    begin
                        idx_reg <= par_w;
                        state_reg <= S_UP_PAR;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_EX_RD0:
                begin
                    if (cnt_reg == '0)
                    begin
                        rsp_reg.status <= ST_EMPTY;
                        state_reg <= S_RSP;
                    end
                    else
                    begin
                        state_reg <= S_EX_KEY0;
                    end
                end
                S_EX_KEY0:
                begin
                    top_reg <= hs_rdata;
                    state_reg <= S_EX_LAST;
                end
                S_EX_LAST:
                begin
                    // hs_rdata holds last slot's vertex, vk_rdata the top key
                    v_reg <= hs_rdata;
                    rsp_reg.out_vertex <= top_reg;
                    rsp_reg.out_key <= vk_rdata;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    state_reg <= (cnt_reg == CNT_W'(1)) ? S_RSP : S_EX_KEYL;
                end
                S_EX_KEYL:
                begin
                    k_reg <= vk_rdata;
                    idx_reg <= '0;
                    state_reg <= S_DN_L;
                end
                S_DN_L:
                begin
                    if (child_w >= cnt_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        ch_reg <= child_w[SLOT_W-1:0];
                        state_reg <= S_DN_LK;
                    end
                end
                S_DN_LK:
                begin
                    cv_reg <= hs_rdata;
                    state_reg <= S_DN_R;
                end
                S_DN_R:
                begin
                    ck_reg <= vk_rdata;
                    state_reg <= (rch_w < cnt_reg) ? S_DN_RK : S_DN_CMP;
                end
                S_DN_RK:
                begin
                    // right child only when left is strictly greater
                    if (ck_reg > vk_rdata)
                    begin
                        ch_reg <= rch_w[SLOT_W-1:0];
                        cv_reg <= hs_rdata;
                        ck_reg <= vk_rdata;
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (k_reg > ck_reg)
                    begin
                        idx_reg <= ch_reg;
                        state_reg <= S_DN_L;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: state_reg <= S_RSP;
                S_RSP:
                begin
                    rsp_valid_reg    <= 1'b1;
                    rsp_reg.count    <= cnt_reg;
                    rsp_reg.is_empty <= (cnt_reg == '0);
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // a response carries a vertex only with ok status
    a_rsp_vtx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.out_vertex == '0)
        else $error("vertex on failed response");
    // empty flag agrees with count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.is_empty == (rsp.count == '0))
        else $error("empty flag mismatch");
    // count never exceeds capacity
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("count overflow");
`endif

endmodule

### bench/indexed_min_heap_queue_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_min_heap_queue_tb
// Self-checking bench for the indexed min-heap queue: a directed table of
// requests, then random insert / decrease / extract / no-op traffic; every
// response compared field by field with a table entry or a heap model.
// ---------------------------------------------------------------------------
module indexed_min_heap_queue_tb;
    import imhq_pkg::*;

    localparam int NV     = 16;   // small vertex pool so inserts collide often
    localparam int N_RAND = 1030;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    // behavioral heap state
    logic [9:0]  hp_slot [CAPACITY];
    logic [31:0] hp_key  [VERTICES];
    int          hp_pos  [VERTICES];
    int          hp_cnt;

    rsp_item_t exp_rsp_q[$];
    req_item_t stim_q[$];
    rsp_item_t fixed_rsp_q[$];
    bit        fixed_use_q[$];
    int        n_mismatch;
    bit        stim_done;
    bit        hold_off;

    indexed_min_heap_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sift element v up from slot idx
    function automatic void heap_rise(input int start_idx, input logic [9:0] v);
        int idx;
        int par;
        idx = start_idx;
        while (idx > 0)
        begin
            par = (idx - 1) / 2;
            if (!(hp_key[hp_slot[par]] > hp_key[v]))
                break;
            hp_slot[idx] = hp_slot[par];
            hp_pos[hp_slot[par]] = idx;
            idx = par;
        end
        hp_slot[idx] = v;
        hp_pos[v] = idx;
    endfunction

    // sift root down within m slots
    function automatic void heap_sink(input int m);
        int idx;
        int ch;
        logic [9:0] v;
        idx = 0;
        v = hp_slot[0];
        forever
        begin
            ch = 2 * idx + 1;
            if (ch >= m)
                break;
            if (ch + 1 < m && hp_key[hp_slot[ch]] > hp_key[hp_slot[ch + 1]])
                ch++;
            if (!(hp_key[v] > hp_key[hp_slot[ch]]))
                break;
            hp_slot[idx] = hp_slot[ch];
            hp_pos[hp_slot[ch]] = idx;
            idx = ch;
        end
        hp_slot[idx] = v;
        hp_pos[v] = idx;
    endfunction

    // apply one request to the heap model, return the expected response
    function automatic rsp_item_t heap_apply(input req_item_t r);
        rsp_item_t  e;
        logic [9:0] top;
        int         last;
        e = '0;
        e.status = ST_OK;
        case (req_t'(r.req_type))
            REQ_INSERT:
            begin
                if (hp_pos[r.vertex] >= 0 || hp_cnt >= CAPACITY)
                    e.status = ST_FULL;
                else
                begin
                    hp_key[r.vertex] = r.new_key;
                    heap_rise(hp_cnt, r.vertex);
                    hp_cnt++;
                end
            end
            REQ_DECREASE:
            begin
                if (hp_pos[r.vertex] < 0)
                    e.status = ST_ABSENT;
                else if (!(r.new_key < hp_key[r.vertex]))
                    e.status = ST_NOT_LOW;
                else
                begin
                    hp_key[r.vertex] = r.new_key;
                    heap_rise(hp_pos[r.vertex], r.vertex);
                end
            end
            REQ_EXTRACT:
            begin
                if (hp_cnt == 0)
                    e.status = ST_EMPTY;
                else
                begin
                    last = hp_cnt - 1;
                    top = hp_slot[0];
                    e.out_vertex = top;
                    e.out_key = hp_key[top];
                    hp_pos[top] = -1;
                    hp_cnt = last;
                    if (last > 0)
                    begin
                        hp_slot[0] = hp_slot[last];
                        hp_pos[hp_slot[0]] = 0;
                        heap_sink(last);
                    end
                    hp_slot[last] = top;
                end
            end
            default: ;
        endcase
        e.count = hp_cnt[10:0];
        e.is_empty = (hp_cnt == 0);
        return e;
    endfunction

    function automatic req_item_t mk_req(input req_t t, input int v, input logic [31:0] k);
        req_item_t r;
        r.req_type = t;
        r.vertex = v[9:0];
        r.new_key = k;
        return r;
    endfunction

    // directed table row, with optional fixed expectation
    task automatic add_row(input req_t t, input int v, input logic [31:0] k,
                           input bit use_fixed, input rsp_item_t fx);
        stim_q.push_back(mk_req(t, v, k));
        fixed_use_q.push_back(use_fixed);
        fixed_rsp_q.push_back(fx);
    endtask

    function automatic rsp_item_t fx_rsp(input status_t s, input int cnt);
        rsp_item_t e;
        e = '0;
        e.status = s;
        e.count = cnt[10:0];
        e.is_empty = (cnt == 0);
        return e;
    endfunction

    // random request, mostly to a small vertex pool, with key shapes
    function automatic req_item_t rand_req();
        int          sel;
        int          v;
        logic [31:0] k;
        sel = $urandom_range(0, 99);
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, NV - 1);
        case ($urandom_range(0, 3))
            0: k = $urandom;
            1: k = $urandom_range(0, 15);
            2: k = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: k = $urandom_range(0, 255) << 16;
        endcase
        if (sel < 40)
            return mk_req(REQ_INSERT, v, k);
        else if (sel < 65)
        begin
            if (v < NV && hp_pos[v] >= 0 && $urandom_range(0, 3) != 0)
                k = hp_key[v] - $urandom_range(0, 3);
            return mk_req(REQ_DECREASE, v, k);
        end
        else if (sel < 97)
            return mk_req(REQ_EXTRACT, v, k);
        return mk_req(REQ_NOP, v, k);
    endfunction

    // sender
    initial
    begin : sender
        int        gap;
        bit        fx;
        rsp_item_t fr;
        rsp_item_t e;
        req_item_t r;
        int        i;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        stim_done = 1'b0;
        n_mismatch = 0;
        hp_cnt = 0;
        for (i = 0; i < VERTICES; i++)
            hp_pos[i] = -1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        add_row(REQ_EXTRACT,  0,    32'h0,        1, fx_rsp(ST_EMPTY, 0));
        add_row(REQ_DECREASE, 5,    32'h1,        1, fx_rsp(ST_ABSENT, 0));
        add_row(REQ_NOP,      0,    32'h0,        1, fx_rsp(ST_OK, 0));
        add_row(REQ_INSERT,   1023, 32'hFFFF_FFFF, 1, fx_rsp(ST_OK, 1));
        add_row(REQ_INSERT,   1023, 32'h5,        1, fx_rsp(ST_FULL, 1));
        add_row(REQ_DECREASE, 1023, 32'hFFFF_FFFF, 1, fx_rsp(ST_NOT_LOW, 1));
        add_row(REQ_INSERT,   0,    32'h0,        0, '0);
        add_row(REQ_INSERT,   7,    32'h0001_0000, 0, '0);
        add_row(REQ_INSERT,   8,    32'h0001_0000, 0, '0);
        add_row(REQ_INSERT,   9,    32'h0000_8000, 0, '0);
        add_row(REQ_INSERT,   682,  32'hAAAA_5555, 0, '0);
        add_row(REQ_INSERT,   341,  32'h5555_AAAA, 0, '0);
        add_row(REQ_DECREASE, 1023, 32'h0,        0, '0);
        add_row(REQ_DECREASE, 8,    32'h0000_7FFF, 0, '0);
        add_row(REQ_DECREASE, 7,    32'h0001_0000, 1, fx_rsp(ST_NOT_LOW, 7));
        add_row(REQ_NOP,      1023, 32'hFFFF_FFFF, 0, '0);
        repeat (9)
            add_row(REQ_EXTRACT, 0, 32'h0, 0, '0);

        for (i = 0; i < stim_q.size() + N_RAND; i++)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            fx = 1'b0;
            if (i < stim_q.size())
            begin
                r = stim_q[i];
                fx = fixed_use_q[i];
                fr = fixed_rsp_q[i];
            end
            else
                r = rand_req();
            req_valid <= 1'b1;
            req <= r;
            @(posedge clk);
            while (!req_ready)
                @(posedge clk);
            // predict at acceptance, in request order
            e = heap_apply(r);
            if (fx && fr != e)
                $display("table row %0d disagrees with heap model", i);
            exp_rsp_q.push_back(fx ? fr : e);
        end
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // long receiver hold-off, counted in cycles after reset
    initial
    begin : hold_ctl
        int cyc;
        hold_off = 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 3000)
                hold_off <= 1'b1;
            if (cyc == 3400)
                hold_off <= 1'b0;
        end
    end

    // receiver with random stalls
    initial
    begin : receiver
        int wait_n;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
            if (wait_n != 0 || hold_off)
            begin
                rsp_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // response check
    always @(posedge clk)
    begin
        rsp_item_t e;
        if (rsp_valid && rsp_ready)
        begin
            if (exp_rsp_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected response transfer %p", rsp);
            end
            else
            begin
                e = exp_rsp_q.pop_front();
                if (rsp !== e)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p, got %p", e, rsp);
                end
            end
        end
    end

    // end of run
    initial
    begin : finisher
        wait (stim_done);
        while (exp_rsp_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (n_mismatch == 0)
            $display("PASS indexed_min_heap_queue");
        else
            $display("FAIL indexed_min_heap_queue");
        $finish;
    end

    // watchdog
    initial
    begin
        #(8 * 400000);
        $display("FAIL indexed_min_heap_queue");
        $finish;
    end

endmodule

### sim.f
rtl/core/imhq_pkg.sv
rtl/core/imhq_ram.sv
rtl/core/indexed_min_heap_queue.sv
bench/indexed_min_heap_queue_tb.sv
